### design/assert_macros.svh
// assertion macros shared by the sorted tag list design
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds in the same cycle as the trigger
`define STL_ASSERT_SAME(label, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("sorted tag list check failed");

// condition holds in the cycle after the trigger
`define STL_ASSERT_NEXT(label, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("sorted tag list check failed");

`endif

### design/stl_pkg.sv
// types and codes shared by the sorted tag list modules
`default_nettype none

package stl_pkg;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_SEARCH = 2'd2;

    localparam int TAG_W   = 32;
    localparam int COUNT_W = 7;

    typedef struct packed {
        logic [1:0]              operation;
        logic signed [TAG_W-1:0] tag;
    } request_t;

    typedef struct packed {
        logic               hit;
        logic               full_reject;
        logic [COUNT_W-1:0] count;
    } response_t;

    // broadcast to every cell for the beat being applied
    typedef struct packed {
        logic insert;
        logic remove;
    } cell_ctl_t;

endpackage

`default_nettype wire

### design/sorted_tag_list.sv
// Sorted tag list: holds up to CAPACITY signed 32-bit tags in ascending order in a
// chain of cells. Each request beat inserts, removes (first equal) or searches one
// tag; every cell compares its tag with the request in parallel and the chain
// shifts by one place, so a request is applied in the cycle it is taken and the
// block takes one request per cycle unless the response stalls; the response is
// registered and appears in the cycle after the request is taken. A request is
// taken whenever the response register is empty or is being emptied in the same
// cycle. The count field carries the low seven bits of the tag count afterwards.
`default_nettype none
`include "assert_macros.svh"

module sorted_tag_list #(
    parameter int CAPACITY = 64
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                request_valid,
    output logic                     request_stall,
    input  wire stl_pkg::request_t   request,
    output logic                     response_valid,
    input  wire logic                response_stall,
    output stl_pkg::response_t       response
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic                             accept;
    logic                             full;
    logic                             any_eq;
    logic [CAPACITY-1:0]              lt_vec;
    logic [CAPACITY-1:0]              eq_vec;
    logic [CAPACITY-1:0]              valid_vec;
    logic signed [stl_pkg::TAG_W-1:0] tag_vec [CAPACITY];
    stl_pkg::cell_ctl_t               ctl;

    logic [CW-1:0]                    count_reg;
    logic [CW-1:0]                    count_next;
    logic [CW+stl_pkg::COUNT_W-1:0]   count_wide;
    logic                             out_valid_reg;
    stl_pkg::response_t               out_reg;
    stl_pkg::response_t               out_next;
    logic                             reject_taken;
    logic                             reject_shown;

    assign request_stall  = out_valid_reg && response_stall;
    assign accept         = request_valid && !request_stall;
    assign full           = (count_reg == CW'(CAPACITY));
    assign any_eq         = |eq_vec;
    assign response_valid = out_valid_reg;
    assign response       = out_reg;
    assign reject_taken   = accept && full && (request.operation == stl_pkg::OP_INSERT);
    assign reject_shown   = response.full_reject && !response.hit;

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            logic                             l_lt;
            logic                             l_valid;
            logic signed [stl_pkg::TAG_W-1:0] l_tag;
            logic                             r_valid;
            logic signed [stl_pkg::TAG_W-1:0] r_tag;

            if (i == 0)
            begin : g_head
                assign l_lt    = 1'b1;
                assign l_valid = 1'b0;
                assign l_tag   = '0;
            end
            else
            begin : g_body
                assign l_lt    = lt_vec[i-1];
                assign l_valid = valid_vec[i-1];
                assign l_tag   = tag_vec[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_tail
                assign r_valid = 1'b0;
                assign r_tag   = '0;
            end
            else
            begin : g_inner
                assign r_valid = valid_vec[i+1];
                assign r_tag   = tag_vec[i+1];
            end

            stl_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctl         (ctl),
                .key         (request.tag),
                .left_lt     (l_lt),
                .left_valid  (l_valid),
                .left_tag    (l_tag),
                .right_valid (r_valid),
                .right_tag   (r_tag),
                .lt          (lt_vec[i]),
                .eq          (eq_vec[i]),
                .valid       (valid_vec[i]),
                .tag         (tag_vec[i])
            );
        end
    endgenerate

    always_comb
    begin
        ctl                  = '0;
        count_next           = count_reg;
        out_next.hit         = 1'b0;
        out_next.full_reject = 1'b0;
        case (request.operation)
            stl_pkg::OP_INSERT:
            begin
                if (full)
                begin
                    out_next.full_reject = 1'b1;
                end
                else
                begin
                    ctl.insert   = accept;
                    count_next   = count_reg + CW'(1);
                    out_next.hit = 1'b1;
                end
            end
            stl_pkg::OP_REMOVE:
            begin
                if (any_eq)
                begin
                    ctl.remove   = accept;
                    count_next   = count_reg - CW'(1);
                    out_next.hit = 1'b1;
                end
            end
            stl_pkg::OP_SEARCH:
            begin
                out_next.hit = any_eq;
            end
            default:
            begin
                out_next.hit = 1'b0;
            end
        endcase
        count_wide     = {{stl_pkg::COUNT_W{1'b0}}, count_next};
        out_next.count = count_wide[stl_pkg::COUNT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (!response_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // response payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_reg <= out_next;
        end
    end

    `STL_ASSERT_SAME(a_count_bound, 1'b1, count_reg <= CW'(CAPACITY))
    `STL_ASSERT_SAME(a_valid_matches_count, 1'b1, $countones(valid_vec) == int'(count_reg))
    `STL_ASSERT_NEXT(a_count_holds, !accept, $stable(count_reg))
    `STL_ASSERT_NEXT(a_full_reject, reject_taken, reject_shown && $stable(count_reg))

endmodule

`default_nettype wire

### design/stl_cell.sv
// one cell of the sorted chain: holds a tag and shifts towards either neighbour
`default_nettype none

module stl_cell (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire stl_pkg::cell_ctl_t                ctl,
    input  wire logic signed [stl_pkg::TAG_W-1:0]  key,
    input  wire logic                              left_lt,
    input  wire logic                              left_valid,
    input  wire logic signed [stl_pkg::TAG_W-1:0]  left_tag,
    input  wire logic                              right_valid,
    input  wire logic signed [stl_pkg::TAG_W-1:0]  right_tag,
    output logic                                   lt,
    output logic                                   eq,
    output logic                                   valid,
    output logic signed [stl_pkg::TAG_W-1:0]       tag
);

    logic                             valid_reg;
    logic                             valid_next;
    logic signed [stl_pkg::TAG_W-1:0] tag_reg;
    logic signed [stl_pkg::TAG_W-1:0] tag_next;

    assign lt    = valid_reg && ($signed(tag_reg) < $signed(key));
    assign eq    = valid_reg && (tag_reg == key);
    assign valid = valid_reg;
    assign tag   = tag_reg;

    // cells holding smaller tags stay put, the rest move
    always_comb
    begin
        valid_next = valid_reg;
        tag_next   = tag_reg;
        if (ctl.insert && !lt)
        begin
            if (left_lt)
            begin
                valid_next = 1'b1;
                tag_next   = key;
            end
            else
            begin
                valid_next = left_valid;
                tag_next   = left_tag;
            end
        end
        else if (ctl.remove && !lt)
        begin
            valid_next = right_valid;
            tag_next   = right_tag;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg <= tag_next;
    end

endmodule

`default_nettype wire
